// ===== sv/tblf_pkg.sv =====
// Shared types, constants and helpers of the trigger band and line filter.
`default_nettype none
package tblf_pkg;

    localparam int MAX_LINES_DEF = 16;

    // Field widths of the items and registers.
    localparam int FREQ_W     = 32;
    localparam int STAT_W     = 32;
    localparam int HW_W       = 30;
    localparam int GAIN_W     = 32;
    localparam int LCNT_W     = 5;
    localparam int EIDX_W     = 4;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int KEPT_W     = 32;

    // Arithmetic unit width: covers a frequency plus the shifted product.
    localparam int ALU_W      = 40;
    localparam int PROD_W     = FREQ_W + GAIN_W;
    localparam int GAIN_SHIFT = 28;
    localparam int SHIFT_W    = PROD_W - GAIN_SHIFT;

    localparam logic signed [ALU_W-1:0] HALF_PI_Q28 = 40'sd421657428;
    localparam logic signed [ALU_W-1:0] PI_Q28      = 40'sd843314857;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_STAT_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd3;

    typedef enum logic [2:0] {
        ST_KEPT        = 3'd0,
        ST_LOW_STAT    = 3'd1,
        ST_OUT_OF_BAND = 3'd2,
        ST_IN_LINE     = 3'd3,
        ST_SHIFTED_OUT = 3'd4,
        ST_TABLE_WR    = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [FREQ_W-1:0] hi;
        logic signed [FREQ_W-1:0] lo;
    } line_entry_t;

    typedef struct packed {
        logic                    sub;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] sum;
        logic                    neg;
        logic                    zero;
    } alu_rsp_t;

    function automatic logic signed [ALU_W-1:0] sext32(input logic [31:0] v);
        return {{(ALU_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [ALU_W-1:0] zext32(input logic [31:0] v);
        return {{(ALU_W-32){1'b0}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== sv/tblf_alu.sv =====
// Shared add/subtract unit with sign and zero flags.
`default_nettype none
module tblf_alu (
    input  tblf_pkg::alu_req_t req,
    output tblf_pkg::alu_rsp_t rsp
);
    import tblf_pkg::*;

    logic signed [ALU_W-1:0] sum;

    assign sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
    assign rsp.sum  = sum;
    assign rsp.neg  = sum[ALU_W-1];
    assign rsp.zero = (sum == '0);

endmodule
`default_nettype wire

// ===== sv/tblf_line_mem.sv =====
// Line interval table: one write port, one registered read port.
`default_nettype none
module tblf_line_mem #(
    parameter int DEPTH  = tblf_pkg::MAX_LINES_DEF,
    parameter int ADDR_W = 4
) (
    input  wire                    aclk,
    input  wire                    wr_en,
    input  wire [ADDR_W-1:0]       wr_addr,
    input  tblf_pkg::line_entry_t  wr_data,
    input  wire [ADDR_W-1:0]       rd_addr,
    output tblf_pkg::line_entry_t  rd_data
);
    import tblf_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/trigger_band_line_filter.sv =====
// Trigger qualifier: threshold, band, line veto and spindown shift checks in sequence.
// A table item (s_tuser high) writes its line entry and goes straight to the result;
// a trigger passes the statistic test, the low and high band bounds, the line scan
// (up to two compares per entry) and the shift test, and stops at the first reject.
// One item at a time; s_tready is high only when the sequencer is idle.
// aresetn (sync, active low) clears config, kept count and handshake; table is unset.
`default_nettype none
module trigger_band_line_filter #(
    parameter int MAX_LINES = tblf_pkg::MAX_LINES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // s_tdata, low bit up: freq[32], stat_value[32], spindown[32], entry_index[4],
    // entry_low[32], entry_high[32], zero pad[4]
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [tblf_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: func[1]
    input  wire                                s_tuser,
    // m_tdata, low bit up: status[3], zero pad[5]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [tblf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire                                cfg_wr_en,
    input  wire [tblf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [tblf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tblf_pkg::*;

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W = $clog2(MAX_LINES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STAT,
        S_BLO_CALC,
        S_BLO,
        S_BHI_CALC,
        S_BHI,
        S_LINE_LO,
        S_LINE_HI,
        S_SHIFT,
        S_CHECK,
        S_FINISH
    } state_t;

    // Input item fields.
    logic                     in_func;
    logic [FREQ_W-1:0]        in_freq;
    logic [STAT_W-1:0]        in_stat;
    logic [GAIN_W-1:0]        in_spin;
    logic [EIDX_W-1:0]        in_eidx;
    line_entry_t              in_entry;

    assign in_func     = s_tuser;
    assign in_freq     = s_tdata[31:0];
    assign in_stat     = s_tdata[63:32];
    assign in_spin     = s_tdata[95:64];
    assign in_eidx     = s_tdata[99:96];
    assign in_entry.lo = s_tdata[131:100];
    assign in_entry.hi = s_tdata[163:132];

    // Configuration registers.
    logic [STAT_W-1:0]        stat_thr_reg;
    logic [HW_W-1:0]          half_width_reg;
    logic signed [GAIN_W-1:0] shift_gain_reg;
    logic [LCNT_W-1:0]        line_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_thr_reg   <= '0;
            half_width_reg <= '0;
            shift_gain_reg <= '0;
            line_count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STAT_THR:   stat_thr_reg   <= cfg_wdata;
                REG_HALF_WIDTH: half_width_reg <= cfg_wdata[HW_W-1:0];
                REG_SHIFT_GAIN: shift_gain_reg <= cfg_wdata;
                REG_LINE_COUNT: line_count_reg <= cfg_wdata[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer registers.
    state_t                   state_reg, state_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;
    logic signed [GAIN_W-1:0] spin_reg, spin_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ALU_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         limit_reg, limit_next;
    status_t                  result_reg, result_next;
    status_t                  m_status_reg, m_status_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [KEPT_W-1:0]        kept_reg, kept_next;

    logic                     in_accept;
    logic                     mem_wr_en;
    line_entry_t              line_rd;
    logic [CNT_W-1:0]         idx_plus;
    logic signed [ALU_W-1:0]  shift_ext;
    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign mem_wr_en = in_accept && in_func && (32'(in_eidx) < MAX_LINES);
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign shift_ext = {{(ALU_W-SHIFT_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:GAIN_SHIFT]};

    tblf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tblf_line_mem #(
        .DEPTH  (MAX_LINES),
        .ADDR_W (IDX_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (IDX_W'(in_eidx)),
        .wr_data (in_entry),
        .rd_addr (idx_next[IDX_W-1:0]),
        .rd_data (line_rd)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.sub = 1'b1;
        alu_req.a   = sext32(freq_reg);
        alu_req.b   = acc_reg;
        unique case (state_reg)
            S_STAT: begin
                alu_req.a = zext32(stat_reg);
                alu_req.b = zext32(stat_thr_reg);
            end
            S_BLO_CALC: begin
                alu_req.a = HALF_PI_Q28;
                alu_req.b = ALU_W'(half_width_reg);
            end
            S_BHI_CALC: begin
                alu_req.sub = 1'b0;
                alu_req.a   = HALF_PI_Q28;
                alu_req.b   = ALU_W'(half_width_reg);
            end
            S_LINE_LO: begin
                alu_req.b = sext32(line_rd.lo);
            end
            S_LINE_HI: begin
                alu_req.a = sext32(line_rd.hi);
                alu_req.b = sext32(freq_reg);
            end
            S_SHIFT: begin
                alu_req.sub = 1'b0;
                alu_req.b   = shift_ext;
            end
            S_CHECK: begin
                alu_req.a = acc_reg;
                alu_req.b = PI_Q28;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        freq_next     = freq_reg;
        stat_next     = stat_reg;
        spin_next     = spin_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        idx_next      = '0;
        limit_next    = limit_reg;
        result_next   = result_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kept_next     = kept_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_func) begin
                        result_next = ST_TABLE_WR;
                        state_next  = S_FINISH;
                    end else begin
                        freq_next  = in_freq;
                        stat_next  = in_stat;
                        spin_next  = in_spin;
                        limit_next = (32'(line_count_reg) > MAX_LINES) ?
                                     CNT_W'(MAX_LINES) : CNT_W'(line_count_reg);
                        state_next = S_STAT;
                    end
                end
            end
            S_STAT: begin
                prod_next = spin_reg * shift_gain_reg;
                if (alu_rsp.neg) begin
                    result_next = ST_LOW_STAT;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_BLO_CALC;
                end
            end
            S_BLO_CALC: begin
                acc_next   = alu_rsp.sum;
                state_next = S_BLO;
            end
            S_BLO: begin
                if (alu_rsp.neg || alu_rsp.zero) begin
                    result_next = ST_OUT_OF_BAND;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_BHI_CALC;
                end
            end
            S_BHI_CALC: begin
                acc_next   = alu_rsp.sum;
                state_next = S_BHI;
            end
            S_BHI: begin
                if (!alu_rsp.neg) begin
                    result_next = ST_OUT_OF_BAND;
                    state_next  = S_FINISH;
                end else if (limit_reg == '0) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_LINE_LO;
                end
            end
            S_LINE_LO: begin
                if (alu_rsp.neg) begin
                    // below the interval start: advance to the next entry
                    if (idx_plus == limit_reg) begin
                        state_next = S_SHIFT;
                    end else begin
                        idx_next = idx_plus;
                    end
                end else begin
                    idx_next   = idx_reg;
                    state_next = S_LINE_HI;
                end
            end
            S_LINE_HI: begin
                if (alu_rsp.neg) begin
                    if (idx_plus == limit_reg) begin
                        state_next = S_SHIFT;
                    end else begin
                        idx_next   = idx_plus;
                        state_next = S_LINE_LO;
                    end
                end else begin
                    result_next = ST_IN_LINE;
                    state_next  = S_FINISH;
                end
            end
            S_SHIFT: begin
                acc_next   = alu_rsp.sum;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_FINISH;
                if (acc_reg[ALU_W-1] || (!alu_rsp.neg && !alu_rsp.zero)) begin
                    result_next = ST_SHIFTED_OUT;
                end else begin
                    result_next = ST_KEPT;
                    kept_next   = kept_reg + KEPT_W'(1);
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_status_next = result_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            kept_reg     <= '0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            kept_reg     <= kept_next;
            idx_reg      <= idx_next;
        end
        freq_reg     <= freq_next;
        stat_reg     <= stat_next;
        spin_reg     <= spin_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        limit_reg    <= limit_next;
        result_reg   <= result_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-3){1'b0}}, m_status_reg};

endmodule
`default_nettype wire

// ===== sv/tblf_checker.sv =====
// Port-level checks of the trigger filter, bound to the top level.
`default_nettype none
module tblf_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            s_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [tblf_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tblf_pkg::*;

    // No result right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Status code stays within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7))
        else $error("undefined status code");

    // One item at a time: input closes after an accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // A table item accepted with a free output is acknowledged through the finish state and the output register.
    a_table_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser && !m_tvalid) |=> ##1
        (m_tvalid && m_tdata[2:0] == ST_TABLE_WR))
        else $error("table write not acknowledged");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind trigger_band_line_filter tblf_checker u_tblf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the trigger band and line filter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tblf_pkg::*;

    localparam int    MAX_LINES      = MAX_LINES_DEF;
    localparam longint HALF_PI_FX    = 64'sd421657428;
    localparam longint PI_FX         = 64'sd843314857;
    localparam int    BAND_MAX       = 536870912;
    localparam int    PHASES         = 12;
    localparam int    ITEMS_PER_PHASE = 150;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT = 3000;
    localparam int    SETTLE_CYCLES  = 60;

    typedef struct packed {
        logic              func;
        logic [31:0]       freq;
        logic [31:0]       stat;
        logic [31:0]       spindown;
        logic [EIDX_W-1:0] idx;
        logic [31:0]       lo;
        logic [31:0]       hi;
    } trig_item_t;

    typedef struct {
        bit                     is_reg;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        trig_item_t             item;
        bit                     typed;
        status_t                want;
    } stim_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    // Shadow copy of the block's registers and line table.
    logic [STAT_W-1:0]       cfg_thr;
    logic [HW_W-1:0]         cfg_half_width;
    logic [GAIN_W-1:0]       cfg_gain;
    logic [LCNT_W-1:0]       cfg_lines;
    logic [31:0]             line_lo [MAX_LINES];
    logic [31:0]             line_hi [MAX_LINES];
    logic [MAX_LINES-1:0]    line_set;

    status_t                 pending_status[$];
    stim_row_t               stim_rows[$];
    status_t                 want_status;
    int                      mismatch_count;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      hold_req;
    int                      hold_ack;
    int                      quiet_cycles;

    trigger_band_line_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one accepted item to the shadow state and return its status.
    function automatic status_t qualify_or_store(input trig_item_t it);
        longint f;
        longint prod;
        longint shifted;
        int     scan;
        if (it.func) begin
            line_lo[it.idx]  = it.lo;
            line_hi[it.idx]  = it.hi;
            line_set[it.idx] = 1'b1;
            return ST_TABLE_WR;
        end
        f = longint'($signed(it.freq));
        if (it.stat < cfg_thr)
            return ST_LOW_STAT;
        if (f <= HALF_PI_FX - longint'(cfg_half_width) ||
            f >= HALF_PI_FX + longint'(cfg_half_width))
            return ST_OUT_OF_BAND;
        scan = (cfg_lines > MAX_LINES) ? MAX_LINES : int'(cfg_lines);
        for (int k = 0; k < scan; k++) begin
            if (f >= longint'($signed(line_lo[k])) && f <= longint'($signed(line_hi[k])))
                return ST_IN_LINE;
        end
        prod    = longint'($signed(it.spindown)) * longint'($signed(cfg_gain));
        shifted = f + (prod >>> GAIN_SHIFT);
        if (shifted < 0 || shifted > PI_FX)
            return ST_SHIFTED_OUT;
        return ST_KEPT;
    endfunction

    // Largest line count whose scan touches only written entries.
    function automatic int line_limit();
        int n;
        n = 0;
        while (n < MAX_LINES && line_set[n])
            n++;
        return (n == MAX_LINES) ? (1 << LCNT_W) - 1 : n;
    endfunction

    function automatic logic [31:0] band_freq();
        longint span;
        span = 2 * longint'(cfg_half_width);
        return 32'(HALF_PI_FX - longint'(cfg_half_width)
                   + longint'($urandom_range(0, span[31:0])));
    endfunction

    function automatic trig_item_t random_item(input int table_pct);
        trig_item_t  it;
        logic [31:0] add;
        longint      hw;
        longint      fl;
        longint      lo;
        longint      hi;
        int          scan;
        int          k;
        it.func     = 1'b0;
        it.freq     = $urandom;
        it.stat     = $urandom;
        it.spindown = $urandom;
        it.idx      = EIDX_W'($urandom_range(MAX_LINES - 1));
        it.lo       = $urandom;
        it.hi       = $urandom;
        hw          = longint'(cfg_half_width);
        if ($urandom_range(99) < table_pct) begin
            it.func = 1'b1;
            // fill the table from the bottom until every entry holds a line
            if (line_set != '1 && $urandom_range(1)) begin
                for (k = MAX_LINES - 1; k >= 0; k--)
                    if (!line_set[k])
                        it.idx = EIDX_W'(k);
            end
            case ($urandom_range(3))
                0, 1: begin
                    it.lo = band_freq();
                    it.hi = it.lo + $urandom_range(1 << 20);
                end
                2: begin
                    it.lo = band_freq();
                    it.hi = it.lo - $urandom_range(1, 1000);
                end
                default: ;
            endcase
            return it;
        end
        add = $urandom >> $urandom_range(31);
        case ($urandom_range(5))
            0: it.stat = cfg_thr;
            1: it.stat = cfg_thr - 1;
            2, 3, 4: it.stat = (cfg_thr > ~add) ? 32'hFFFF_FFFF : cfg_thr + add;
            default: ;
        endcase
        scan = (cfg_lines > MAX_LINES) ? MAX_LINES : int'(cfg_lines);
        case ($urandom_range(9))
            0, 1, 2, 3: it.freq = band_freq();
            4, 5: begin
                if (scan == 0) begin
                    it.freq = band_freq();
                end else begin
                    k  = $urandom_range(scan - 1);
                    lo = longint'($signed(line_lo[k]));
                    hi = longint'($signed(line_hi[k]));
                    case ($urandom_range(4))
                        0: fl = lo;
                        1: fl = hi;
                        2: fl = lo - 1;
                        3: fl = hi + 1;
                        default: fl = lo + (hi - lo) / 2;
                    endcase
                    it.freq = 32'(fl);
                end
            end
            6: begin
                case ($urandom_range(6))
                    0: fl = HALF_PI_FX - hw;
                    1: fl = HALF_PI_FX + hw;
                    2: fl = HALF_PI_FX - hw + 1;
                    3: fl = HALF_PI_FX + hw - 1;
                    4: fl = 0;
                    5: fl = PI_FX;
                    default: fl = PI_FX + 1;
                endcase
                it.freq = 32'(fl);
            end
            default: ;
        endcase
        case ($urandom_range(3))
            0: it.spindown = '0;
            1, 2: begin
                add = $urandom >> $urandom_range(31);
                it.spindown = $urandom_range(1) ? -add : add;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_STAT_THR:   cfg_thr        = val;
            REG_HALF_WIDTH: cfg_half_width = val[HW_W-1:0];
            REG_SHIFT_GAIN: cfg_gain       = val;
            REG_LINE_COUNT: cfg_lines      = val[LCNT_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one item, wait for the handshake, then queue its expected status.
    task automatic send_item(input trig_item_t it, input bit typed, input status_t want);
        status_t got;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'b0, it.hi, it.lo, it.idx, it.spindown, it.stat, it.freq};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        got = qualify_or_store(it);
        pending_status.push_back(typed ? want : got);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.item    = '0;
        r.typed   = 1'b0;
        r.want    = ST_KEPT;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_trig(input longint freq, input logic [31:0] stat,
                                     input logic [31:0] sd, input bit typed,
                                     input status_t want);
        stim_row_t r;
        r.is_reg        = 1'b0;
        r.reg_idx       = REG_STAT_THR;
        r.reg_val       = '0;
        r.item          = '1;
        r.item.func     = 1'b0;
        r.item.freq     = 32'(freq);
        r.item.stat     = stat;
        r.item.spindown = sd;
        r.typed         = typed;
        r.want          = want;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_table(input int idx, input longint lo, input longint hi);
        stim_row_t r;
        r.is_reg    = 1'b0;
        r.reg_idx   = REG_STAT_THR;
        r.reg_val   = '0;
        r.item      = '1;
        r.item.func = 1'b1;
        r.item.idx  = EIDX_W'(idx);
        r.item.lo   = 32'(lo);
        r.item.hi   = 32'(hi);
        r.typed     = 1'b1;
        r.want      = ST_TABLE_WR;
        stim_rows.push_back(r);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        hold_ack = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, m_tdata[2:0]);
                mismatch_count++;
            end else begin
                want_status = pending_status.pop_front();
                if (m_tdata[2:0] !== want_status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want_status, m_tdata[2:0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int          phase;
        int          mode;
        int          send_pcts [4];
        int          recv_pcts [4];
        logic [31:0] thr_v;
        logic [31:0] hw_v;
        logic [31:0] gain_v;
        logic [31:0] lines_v;
        logic [31:0] mag;

        send_pcts      = '{0, 62, 0, 30};
        recv_pcts      = '{0, 0, 62, 30};
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_STAT_THR;
        cfg_wdata      = '0;
        cfg_thr        = '0;
        cfg_half_width = '0;
        cfg_gain       = '0;
        cfg_lines      = '0;
        line_set       = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        foreach (line_lo[k]) begin
            line_lo[k] = '0;
            line_hi[k] = '0;
        end

        // Directed: reset state, extremes, every reject reason and edge.
        add_trig(HALF_PI_FX, 32'h0, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_table(0, HALF_PI_FX - 1000, HALF_PI_FX + 1000);
        add_table(1, -64'sd2147483648, -64'sd2147483648);
        add_table(MAX_LINES - 1, 64'sd2147483647, -64'sd2147483648);
        add_reg(REG_STAT_THR, 32'hFFFF_FFFF);
        add_trig(HALF_PI_FX, 32'hFFFF_FFFE, 32'h0, 1'b1, ST_LOW_STAT);
        add_trig(HALF_PI_FX, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_reg(REG_HALF_WIDTH, BAND_MAX);
        add_reg(REG_STAT_THR, 32'h0001_0000);
        add_trig(HALF_PI_FX, 32'h0000_FFFF, 32'h0, 1'b1, ST_LOW_STAT);
        add_trig(HALF_PI_FX - BAND_MAX, 32'h0001_0000, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_trig(HALF_PI_FX + BAND_MAX, 32'h0001_0000, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_trig(-64'sd2147483648, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_trig(64'sd2147483647, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OUT_OF_BAND);
        add_trig(HALF_PI_FX - BAND_MAX + 1, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + BAND_MAX - 1, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(0, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(PI_FX, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(PI_FX + 1, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_reg(REG_LINE_COUNT, 32'd2);
        add_trig(HALF_PI_FX, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 1000, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 1001, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_KEPT);
        add_reg(REG_SHIFT_GAIN, 32'h7FFF_FFFF);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_KEPT);
        add_reg(REG_SHIFT_GAIN, 32'h8000_0000);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, ST_KEPT);
        add_trig(HALF_PI_FX + 2000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, ST_KEPT);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].is_reg) begin
                drain();
                write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
            end else begin
                send_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            mode           = phase % 4;
            send_idle_pct  = send_pcts[mode];
            recv_stall_pct = recv_pcts[mode];

            mag    = $urandom >> $urandom_range(31);
            thr_v  = $urandom >> $urandom_range(31);
            hw_v   = $urandom_range(0, BAND_MAX);
            gain_v = $urandom_range(1) ? -mag : mag;
            case (phase)
                0: begin
                    thr_v  = '0;
                    hw_v   = BAND_MAX;
                    gain_v = '0;
                end
                1: begin
                    thr_v  = 32'hFFFF_FFFF;
                    hw_v   = '0;
                    gain_v = 32'h7FFF_FFFF;
                end
                2: gain_v = 32'h8000_0000;
                default: ;
            endcase
            // prefer the full table and the out-of-range count once available
            if (phase == 2 && line_limit() > MAX_LINES)
                lines_v = MAX_LINES;
            else if (phase == 3)
                lines_v = line_limit();
            else
                lines_v = $urandom_range(0, line_limit());

            write_reg(REG_STAT_THR, thr_v);
            write_reg(REG_HALF_WIDTH, hw_v);
            write_reg(REG_SHIFT_GAIN, gain_v);
            write_reg(REG_LINE_COUNT, lines_v);

            // hold the result side off while items keep coming
            if (phase == 2)
                hold_req++;

            repeat (ITEMS_PER_PHASE)
                send_item(random_item(phase == 0 ? 50 : 15), 1'b0, ST_KEPT);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
